@@ rtl/core/ihex_pkg.sv @@
// shared types and constants for the intel hex record parser
`default_nettype none

package ihex_pkg;

	localparam int IDX_W = 6;

	localparam logic [7:0] CHAR_COLON = 8'h3A;

	localparam logic [7:0] REC_DATA    = 8'h00;
	localparam logic [7:0] REC_EOF     = 8'h01;
	localparam logic [7:0] REC_SEGMENT = 8'h02;
	localparam logic [7:0] REC_LINEAR  = 8'h04;

	localparam logic [3:0] ST_DATA_OK    = 4'd0;
	localparam logic [3:0] ST_END_OK     = 4'd1;
	localparam logic [3:0] ST_SEGMENT_OK = 4'd2;
	localparam logic [3:0] ST_LINEAR_OK  = 4'd3;
	localparam logic [3:0] ST_NO_COLON   = 4'd4;
	localparam logic [3:0] ST_SHORT      = 4'd5;
	localparam logic [3:0] ST_LENGTH     = 4'd6;
	localparam logic [3:0] ST_BAD_HEX    = 4'd7;
	localparam logic [3:0] ST_CHECKSUM   = 4'd8;
	localparam logic [3:0] ST_UNSUPPORT  = 4'd9;
	localparam logic [3:0] ST_TOO_LONG   = 4'd10;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic [7:0] text_char;
		logic       line_end;
	} ihex_in_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] write_address;
		logic [7:0]  write_byte;
		logic [3:0]  status;
		logic        flush_request;
		logic        last;
	} ihex_out_t;

	typedef struct packed {
		logic             is_cmd;
		logic [IDX_W-1:0] idx;
		logic [7:0]       data;
		logic [3:0]       status;
		logic [IDX_W-1:0] count;
		logic [15:0]      offset;
		logic [15:0]      pair;
	} ihex_entry_t;

endpackage

`default_nettype wire

@@ rtl/core/intel_hex_record_parser_top.sv @@
// top level of the intel hex record parser
//
// channel   direction  handshake       transfer when
// item      in         push / full     push && !full
// result    out        empty / pop     pop && !empty
//
// one character is taken per cycle while the internal queue has room
// the emitter pops one queue entry per cycle while idle; after the command of a
// valid data record of n bytes it emits n writes (each a buffer read, then the
// output register) and one status; other lines emit one status
// full rises when the four-entry queue between decoder and emitter is full
// a stalled pop holds the result register and, through the queue, the input
// reset clears all line state and the base address; no clearing pass is needed
`default_nettype none

module intel_hex_record_parser_top import ihex_pkg::*; #(
	parameter int MAX_DATA = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	output logic           full,
	input  wire ihex_in_t  item,
	output logic           empty,
	input  wire logic      pop,
	output ihex_out_t      result
);

	logic        q_push;
	logic        q_full;
	logic        q_pop;
	logic        q_empty;
	ihex_entry_t q_wr_entry;
	ihex_entry_t q_rd_entry;

	assign full = q_full;

	ihex_front #(
		.MAX_DATA(MAX_DATA)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item    (item),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_wr_entry)
	);

	ihex_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_entry (q_wr_entry),
		.q_full   (q_full),
		.rd_en    (q_pop),
		.q_empty  (q_empty),
		.rd_entry (q_rd_entry)
	);

	ihex_back #(
		.MAX_DATA(MAX_DATA)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_entry (q_rd_entry),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.last == result.kind))
		else $error("last flag does not match result kind");

	a_flush_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.flush_request) |-> (result.status == ST_END_OK))
		else $error("flush request without end record status");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue written while full");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue read while empty");

endmodule

`default_nettype wire

@@ rtl/core/ihex_front.sv @@
// character decoder: colon check, hex pairs, checksum, record classification
`default_nettype none

module ihex_front import ihex_pkg::*; #(
	parameter int MAX_DATA = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire ihex_in_t    item,
	input  wire logic        q_full,
	output logic             q_push,
	output ihex_entry_t      q_entry
);

	logic [9:0] cc_q, cc_n;
	logic [3:0] nib_q, nib_n;
	logic [7:0] sum_q, sum_n;
	logic [7:0] len_q, len_n;
	logic [15:0] off_q, off_n;
	logic [7:0] typ_q, typ_n;
	logic [8:0] br_q, br_n;
	logic [3:0] err_q, err_n;
	logic [7:0] d0_q, d0_n;
	logic [7:0] d1_q, d1_n;

	logic       acc;
	logic       store;
	logic       bad;
	logic [3:0] nib;
	logic [7:0] byte_v;
	logic [8:0] dat_idx;
	logic       needed;
	logic [3:0] st;
	logic [7:0] c;

	assign acc = push && !q_full;
	assign c   = item.text_char;

	always_comb begin
		bad = 1'b0;
		nib = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			nib = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			nib = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			nib = 4'(c - 8'h57);
		end else begin
			bad = 1'b1;
		end
	end

	assign byte_v  = {nib_q, nib};
	assign dat_idx = br_q - 9'd4;
	assign needed  = (br_q < 9'd4) || ({1'b0, br_q} <= 10'd4 + {2'b0, len_q});

	always_comb begin
		cc_n  = cc_q;
		nib_n = nib_q;
		sum_n = sum_q;
		len_n = len_q;
		off_n = off_q;
		typ_n = typ_q;
		br_n  = br_q;
		err_n = err_q;
		d0_n  = d0_q;
		d1_n  = d1_q;
		store = 1'b0;
		if (cc_q == 10'd0) begin
			if (c != CHAR_COLON && err_q == ST_DATA_OK) begin
				err_n = ST_NO_COLON;
			end
			cc_n = 10'd1;
		end else if (cc_q < 10'd1023) begin
			cc_n = cc_q + 10'd1;
			if (err_q != ST_NO_COLON && needed) begin
				if (bad && err_q == ST_DATA_OK) begin
					err_n = ST_BAD_HEX;
				end
				if (cc_q[0]) begin
					nib_n = nib;
				end else begin
					sum_n = sum_q + byte_v;
					priority if (br_q == 9'd0) begin
						len_n = byte_v;
					end else if (br_q == 9'd1) begin
						off_n = {byte_v, off_q[7:0]};
					end else if (br_q == 9'd2) begin
						off_n = {off_q[15:8], byte_v};
					end else if (br_q == 9'd3) begin
						typ_n = byte_v;
					end else if (dat_idx < {1'b0, len_q} && dat_idx < 9'(MAX_DATA)) begin
						store = 1'b1;
						if (dat_idx == 9'd0) begin
							d0_n = byte_v;
						end
						if (dat_idx == 9'd1) begin
							d1_n = byte_v;
						end
					end
					if (br_q < 9'd511) begin
						br_n = br_q + 9'd1;
					end
				end
			end
		end
	end

	always_comb begin
		priority if (err_n == ST_NO_COLON) begin
			st = ST_NO_COLON;
		end else if (cc_n < 10'd9) begin
			st = ST_SHORT;
		end else if (err_n == ST_BAD_HEX) begin
			st = ST_BAD_HEX;
		end else if ({1'b0, br_n} < 10'd5 + {2'b0, len_n}) begin
			st = ST_LENGTH;
		end else if ({1'b0, len_n} > 9'(MAX_DATA)) begin
			st = ST_TOO_LONG;
		end else if (sum_n != 8'd0) begin
			st = ST_CHECKSUM;
		end else if (typ_n == REC_DATA) begin
			st = ST_DATA_OK;
		end else if (typ_n == REC_EOF) begin
			st = ST_END_OK;
		end else if (typ_n == REC_SEGMENT) begin
			st = ST_SEGMENT_OK;
		end else if (typ_n == REC_LINEAR) begin
			st = ST_LINEAR_OK;
		end else begin
			st = ST_UNSUPPORT;
		end
	end

	assign q_push = acc && (item.line_end || store);

	always_comb begin
		q_entry        = '0;
		q_entry.is_cmd = item.line_end;
		q_entry.idx    = dat_idx[IDX_W-1:0];
		q_entry.data   = byte_v;
		q_entry.status = st;
		q_entry.count  = len_n[IDX_W-1:0];
		q_entry.offset = off_n;
		q_entry.pair   = {(len_n > 8'd0) ? d0_q : 8'd0, (len_n > 8'd1) ? d1_q : 8'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q  <= '0;
			nib_q <= '0;
			sum_q <= '0;
			len_q <= '0;
			off_q <= '0;
			typ_q <= '0;
			br_q  <= '0;
			err_q <= ST_DATA_OK;
			d0_q  <= '0;
			d1_q  <= '0;
		end else if (acc) begin
			if (item.line_end) begin
				cc_q  <= '0;
				nib_q <= '0;
				sum_q <= '0;
				len_q <= '0;
				off_q <= '0;
				typ_q <= '0;
				br_q  <= '0;
				err_q <= ST_DATA_OK;
				d0_q  <= '0;
				d1_q  <= '0;
			end else begin
				cc_q  <= cc_n;
				nib_q <= nib_n;
				sum_q <= sum_n;
				len_q <= len_n;
				off_q <= off_n;
				typ_q <= typ_n;
				br_q  <= br_n;
				err_q <= err_n;
				d0_q  <= d0_n;
				d1_q  <= d1_n;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/ihex_fifo.sv @@
// short queue of byte stores and line commands between decoder and emitter
`default_nettype none

module ihex_fifo import ihex_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire ihex_entry_t wr_entry,
	output logic             q_full,
	input  wire logic        rd_en,
	output logic             q_empty,
	output ihex_entry_t      rd_entry
);

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	ihex_entry_t     mem_q [DEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [PW:0]     cnt_q;
	logic            do_wr;
	logic            do_rd;

	assign q_full   = (cnt_q == (PW+1)'(DEPTH));
	assign q_empty  = (cnt_q == '0);
	assign do_wr    = wr_en && !q_full;
	assign do_rd    = rd_en && !q_empty;
	assign rd_entry = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/ihex_back.sv @@
// data buffer, base address and result emission
`default_nettype none

module ihex_back import ihex_pkg::*; #(
	parameter int MAX_DATA = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_empty,
	input  wire ihex_entry_t q_entry,
	output logic             q_pop,
	input  wire logic        pop,
	output logic             empty,
	output ihex_out_t        result
);

	localparam int AW = $clog2(MAX_DATA);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD,
		S_WR,
		S_ST
	} state_t;

	state_t           state_q;
	ihex_entry_t      cmd_q;
	logic [IDX_W-1:0] i_q;
	logic [31:0]      base_q;
	logic             out_vld_q;
	ihex_out_t        out_q;
	logic [7:0]       buf_q [MAX_DATA];
	logic [7:0]       rdata_q;
	logic             out_free;
	logic             out_load;
	logic             mem_we;

	assign out_free = !out_vld_q || pop;
	assign out_load = out_free && (state_q == S_WR || state_q == S_ST);
	assign q_pop    = (state_q == S_IDLE) && !q_empty;
	assign mem_we   = q_pop && !q_entry.is_cmd;
	assign empty    = !out_vld_q;
	assign result   = out_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			buf_q[q_entry.idx[AW-1:0]] <= q_entry.data;
		end
		rdata_q <= buf_q[i_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cmd_q     <= '0;
			i_q       <= '0;
			base_q    <= '0;
			out_vld_q <= 1'b0;
			out_q     <= '0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_pop && q_entry.is_cmd) begin
						cmd_q <= q_entry;
						i_q   <= '0;
						if (q_entry.status == ST_DATA_OK && q_entry.count != '0) begin
							state_q <= S_RD;
						end else begin
							state_q <= S_ST;
						end
					end
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					if (out_free) begin
						out_q.kind          <= KIND_WRITE;
						out_q.write_address <= base_q + {16'd0, cmd_q.offset}
							+ {{(32-IDX_W){1'b0}}, i_q};
						out_q.write_byte    <= rdata_q;
						out_q.status        <= ST_DATA_OK;
						out_q.flush_request <= 1'b0;
						out_q.last          <= 1'b0;
						if (IDX_W'(i_q + 1'b1) == cmd_q.count) begin
							state_q <= S_ST;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_ST: begin
					if (out_free) begin
						out_q.kind          <= KIND_STATUS;
						out_q.write_address <= '0;
						out_q.write_byte    <= '0;
						out_q.status        <= cmd_q.status;
						out_q.flush_request <= (cmd_q.status == ST_END_OK);
						out_q.last          <= 1'b1;
						if (cmd_q.status == ST_END_OK) begin
							base_q <= '0;
						end else if (cmd_q.status == ST_SEGMENT_OK) begin
							base_q <= {12'd0, cmd_q.pair, 4'd0};
						end else if (cmd_q.status == ST_LINEAR_OK) begin
							base_q <= {cmd_q.pair, 16'd0};
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
